// ===== rtl/core/rbs_pkg.sv =====
// Shared constants and types for the ray versus box slab test.
// No dependencies; used by rbs_lane and ray_box_slab_intersect.
package rbs_pkg;

    localparam int AXES = 3;

    typedef struct packed {
        logic dir_zero;
        logic in_slab;
    } rbs_slab_flags_t;

endpackage

// ===== rtl/core/rbs_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// Depends on nothing; instantiated twice in each rbs_lane.
module rbs_div #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [COORD_WIDTH+FRAC_BITS:0] num,
    input  logic [COORD_WIDTH-1:0]        den,
    input  logic                          neg,
    output logic signed [COORD_WIDTH-1:0] quot
);
    localparam int W  = COORD_WIDTH;
    localparam int N  = COORD_WIDTH + FRAC_BITS + 1;
    localparam int CW = N + W;
    localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

    logic [W:0]   rem_reg  [W];
    logic [W-2:0] quo_reg  [W];
    logic [W-2:0] low_reg  [W];
    logic [W-1:0] den_reg  [W];
    logic         neg_reg  [W];
    logic         ovf_reg  [W];

    logic [CW-1:0] ovf_a;
    logic [CW-1:0] ovf_b;
    logic [N-1:0]  num_sh;
    logic [W-1:0]  qmag;

    assign ovf_a  = CW'(num);
    assign ovf_b  = CW'(den) << (W - 1);
    assign num_sh = num >> (W - 1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num_sh[W:0];
            quo_reg[0] <= '0;
            low_reg[0] <= num[W-2:0];
            den_reg[0] <= den;
            neg_reg[0] <= neg;
            ovf_reg[0] <= (ovf_a >= ovf_b);
        end
    end

    for (genvar s = 1; s < W; s++)
    begin : g_stage
        logic [W+1:0] rem2;
        logic         ge;
        assign rem2 = {rem_reg[s-1], low_reg[s-1][W-2]};
        assign ge   = rem2 >= {2'b00, den_reg[s-1]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= ge ? (W+1)'(rem2 - {2'b00, den_reg[s-1]}) : rem2[W:0];
                quo_reg[s] <= {quo_reg[s-1][W-3:0], ge};
                low_reg[s] <= {low_reg[s-1][W-3:0], 1'b0};
                den_reg[s] <= den_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
            end
        end
    end

    assign qmag = {1'b0, quo_reg[W-1]};

    always_comb
    begin
        if (ovf_reg[W-1])
            quot = neg_reg[W-1] ? MIN_V : MAX_V;
        else if (neg_reg[W-1])
            quot = -qmag;
        else
            quot = qmag;
    end

endmodule

// ===== rtl/core/rbs_lane.sv =====
// One axis of the slab test: differences, two quotients, entry/exit sort.
// Depends on rbs_pkg and rbs_div.
module rbs_lane #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [COORD_WIDTH-1:0] origin,
    input  logic signed [COORD_WIDTH-1:0] dir,
    input  logic signed [COORD_WIDTH-1:0] box_min,
    input  logic signed [COORD_WIDTH-1:0] box_max,
    output logic signed [COORD_WIDTH-1:0] t_ent,
    output logic signed [COORD_WIDTH-1:0] t_ext
);
    localparam int W = COORD_WIDTH;
    localparam int N = COORD_WIDTH + FRAC_BITS + 1;
    localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

    logic signed [W:0] dlo;
    logic signed [W:0] dhi;
    logic [W:0]        mlo;
    logic [W:0]        mhi;
    logic [W-1:0]      dmag;
    rbs_pkg::rbs_slab_flags_t flags;

    logic [N-1:0]  num_lo_reg;
    logic [N-1:0]  num_hi_reg;
    logic [W-1:0]  dmag_reg;
    logic          neg_lo_reg;
    logic          neg_hi_reg;
    rbs_pkg::rbs_slab_flags_t flags_reg [W+1];

    logic signed [W-1:0] q0;
    logic signed [W-1:0] q1;
    logic signed [W-1:0] ent_next;
    logic signed [W-1:0] ext_next;
    logic signed [W-1:0] ent_reg;
    logic signed [W-1:0] ext_reg;

    assign dlo  = (W+1)'(box_min) - (W+1)'(origin);
    assign dhi  = (W+1)'(box_max) - (W+1)'(origin);
    assign mlo  = dlo[W] ? (W+1)'(-dlo) : dlo;
    assign mhi  = dhi[W] ? (W+1)'(-dhi) : dhi;
    assign dmag = dir[W-1] ? W'(-dir) : dir;
    assign flags.dir_zero = (dir == '0);
    assign flags.in_slab  = (box_min <= origin) && (origin <= box_max);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_lo_reg   <= {mlo, {FRAC_BITS{1'b0}}};
            num_hi_reg   <= {mhi, {FRAC_BITS{1'b0}}};
            dmag_reg     <= dmag;
            neg_lo_reg   <= dlo[W] ^ dir[W-1];
            neg_hi_reg   <= dhi[W] ^ dir[W-1];
            flags_reg[0] <= flags;
            for (int i = 1; i <= W; i++)
                flags_reg[i] <= flags_reg[i-1];
            ent_reg <= ent_next;
            ext_reg <= ext_next;
        end
    end

    rbs_div #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_lo (
        .clk  (clk),
        .en   (en),
        .num  (num_lo_reg),
        .den  (dmag_reg),
        .neg  (neg_lo_reg),
        .quot (q0)
    );

    rbs_div #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_hi (
        .clk  (clk),
        .en   (en),
        .num  (num_hi_reg),
        .den  (dmag_reg),
        .neg  (neg_hi_reg),
        .quot (q1)
    );

    always_comb
    begin
        if (flags_reg[W].dir_zero)
        begin
            ent_next = flags_reg[W].in_slab ? MIN_V : MAX_V;
            ext_next = flags_reg[W].in_slab ? MAX_V : MIN_V;
        end
        else if (q0 < q1)
        begin
            ent_next = q0;
            ext_next = q1;
        end
        else
        begin
            ent_next = q1;
            ext_next = q0;
        end
    end

    assign t_ent = ent_reg;
    assign t_ext = ext_reg;

endmodule

// ===== rtl/core/ray_box_slab_intersect.sv =====
// Top level of the ray versus axis-aligned box slab test: three axis lanes and merge.
// Depends on rbs_pkg and rbs_lane.
//
// channel  | dir | content
// s_axis   | in  | ray origin, direction, box min and max corners
// m_axis   | out | hit flag, entry and exit distances
//
// Takes one item per cycle unless the output is stalled; results pass the lane
// input registers, the one-bit-per-stage divider, lane sort and merge registers.
// Reset clears only the valid pipe; payload registers are not reset.
// The whole pipe holds when the output item is stalled.
module ray_box_slab_intersect #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // origin_x,y,z, dir_x,y,z, box_min_x,y,z, box_max_x,y,z
    input  logic [12*COORD_WIDTH-1:0]     s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // hit, t_near, t_far, zero pad
    output logic [((2*COORD_WIDTH+8)/8)*8-1:0] m_axis_tdata
);
    localparam int W    = COORD_WIDTH;
    localparam int LAT  = COORD_WIDTH + 3;
    localparam int OW   = ((2*COORD_WIDTH+8)/8)*8;

    logic                en;
    logic [LAT-1:0]      valid_reg;
    logic [LAT-1:0]      valid_next;

    logic signed [W-1:0] ent [rbs_pkg::AXES];
    logic signed [W-1:0] ext [rbs_pkg::AXES];
    logic signed [W-1:0] near_next;
    logic signed [W-1:0] far_next;
    logic signed [W-1:0] near_reg;
    logic signed [W-1:0] far_reg;
    logic                hit_reg;

    assign en            = !valid_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign valid_next    = {valid_reg[LAT-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    for (genvar a = 0; a < rbs_pkg::AXES; a++)
    begin : g_lane
        rbs_lane #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_lane (
            .clk     (clk),
            .en      (en),
            .origin  (s_axis_tdata[a*W +: W]),
            .dir     (s_axis_tdata[(3+a)*W +: W]),
            .box_min (s_axis_tdata[(6+a)*W +: W]),
            .box_max (s_axis_tdata[(9+a)*W +: W]),
            .t_ent   (ent[a]),
            .t_ext   (ext[a])
        );
    end

    always_comb
    begin
        near_next = ent[0];
        far_next  = ext[0];
        for (int a = 1; a < rbs_pkg::AXES; a++)
        begin
            if (ent[a] > near_next)
                near_next = ent[a];
            if (ext[a] < far_next)
                far_next = ext[a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            near_reg <= near_next;
            far_reg  <= far_next;
            hit_reg  <= (near_next < far_next) && (far_next > 0);
        end
    end

    assign m_axis_tvalid = valid_reg[LAT-1];
    assign m_axis_tdata  = OW'({far_reg, near_reg, hit_reg});

    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not track output stall");

    a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && hit_reg) |-> (near_reg < far_reg) && (far_reg > 0))
        else $error("hit reported with empty or behind interval");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output item changed");

endmodule

// ===== bench/tb_ray_box_slab_intersect.sv =====
`timescale 1ns / 100ps
// Testbench for ray_box_slab_intersect: directed table then random ray/box items.
// Depends on the RTL top level only; the directed table or a local predictor checks every result item.
module tb_ray_box_slab_intersect;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int OW = ((2 * CW + 8) / 8) * 8;
    localparam int LATENCY = CW + 3;
    localparam int RANDOM_ITEMS = 1530;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic signed [CW-1:0] QMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] QMIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic signed [CW-1:0] t_far;
        logic signed [CW-1:0] t_near;
        logic                 hit;
    } hit_t;

    typedef struct {
        logic [12*CW-1:0] ray_box;
        logic             known;
        hit_t             want;
    } row_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [12*CW-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OW-1:0] m_axis_tdata;

    hit_t hits_pending[$];
    row_t rows[$];
    int   error_count;
    longint cycles;
    logic [12*CW-1:0] rb;
    logic [63:0] stall_pat;
    int   stall_idx;

    ray_box_slab_intersect #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic signed [CW-1:0] field(logic [12*CW-1:0] v, int k);
        return v[k*CW +: CW];
    endfunction

    function automatic logic signed [CW-1:0] slab_time(logic signed [CW-1:0] p,
                                                       logic signed [CW-1:0] o,
                                                       logic signed [CW-1:0] d);
        logic signed [CW:0]      diff;
        logic signed [CW+FB+1:0] num;
        logic signed [CW+FB+1:0] q;
        diff = $signed({p[CW-1], p}) - $signed({o[CW-1], o});
        num = $signed(diff) <<< FB;
        q = num / $signed(d);
        if (q > $signed({{(FB+2){1'b0}}, QMAX}))
            return QMAX;
        if (q < $signed({{(FB+2){1'b1}}, QMIN}))
            return QMIN;
        return q[CW-1:0];
    endfunction

    function automatic hit_t predict_hit(logic [12*CW-1:0] v);
        hit_t r;
        logic signed [CW-1:0] o, d, lo, hi, t0, t1, en, ex;
        r.t_near = QMIN;
        r.t_far = QMAX;
        for (int a = 0; a < 3; a++)
        begin
            o = field(v, a);
            d = field(v, 3 + a);
            lo = field(v, 6 + a);
            hi = field(v, 9 + a);
            if (d == 0)
            begin
                en = (lo <= o && o <= hi) ? QMIN : QMAX;
                ex = (lo <= o && o <= hi) ? QMAX : QMIN;
            end
            else
            begin
                t0 = slab_time(lo, o, d);
                t1 = slab_time(hi, o, d);
                en = (t0 < t1) ? t0 : t1;
                ex = (t0 < t1) ? t1 : t0;
            end
            if (en > r.t_near)
                r.t_near = en;
            if (ex < r.t_far)
                r.t_far = ex;
        end
        r.hit = (r.t_near < r.t_far && r.t_far > 0);
        return r;
    endfunction

    function automatic logic [12*CW-1:0] pack_ray(logic signed [CW-1:0] f[12]);
        logic [12*CW-1:0] v;
        for (int k = 0; k < 12; k++)
            v[k*CW +: CW] = f[k];
        return v;
    endfunction

    function automatic logic signed [CW-1:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            2: return ($urandom_range(0, 1)) ? QMAX - $urandom_range(0, 3)
                                              : QMIN + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 40)) - 20;
        endcase
    endfunction

    function automatic logic [12*CW-1:0] random_ray();
        logic signed [CW-1:0] f[12];
        logic signed [CW-1:0] c, h;
        int m;
        m = $urandom_range(0, 9);
        for (int k = 0; k < 12; k++)
            f[k] = rand_coord(m < 2 ? 0 : (m < 3 ? 2 : 1));
        if (m >= 3)
        begin
            // build a box, reversed when m is 9, and aim roughly at it
            for (int a = 0; a < 3; a++)
            begin
                c = rand_coord(1);
                h = $urandom_range(1, 1 << 20);
                f[6 + a] = c - h;
                f[9 + a] = c + h;
                if (m == 9)
                begin
                    f[6 + a] = c + h;
                    f[9 + a] = c - h;
                end
                f[3 + a] = (c - f[a]) >>> $urandom_range(0, 4);
                if ($urandom_range(0, 7) == 0)
                    f[3 + a] = 0;
                else if ($urandom_range(0, 7) == 0)
                    f[3 + a] = rand_coord(3);
            end
        end
        return pack_ray(f);
    endfunction

    task automatic add_row(logic signed [CW-1:0] f[12], logic known, hit_t want);
        row_t r;
        r.ray_box = pack_ray(f);
        r.known = known;
        r.want = want;
        rows.push_back(r);
    endtask

    task automatic send_item(logic [12*CW-1:0] v);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= v;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    initial
    begin
        logic signed [CW-1:0] f[12];
        hit_t w;
        int burst;
        int gap;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        error_count = 0;
        stall_pat = {$urandom, $urandom};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unit box, ray along +x from the left
        f = '{-(2 << FB), 0, 0, 1 << FB, 0, 0, -(1 << FB), -(1 << FB), -(1 << FB),
              1 << FB, 1 << FB, 1 << FB};
        w.hit = 1; w.t_near = 1 << FB; w.t_far = 3 << FB;
        add_row(f, 1, w);
        // zero direction everywhere, origin inside
        f = '{0, 0, 0, 0, 0, 0, -1, -1, -1, 1, 1, 1};
        w.hit = 1; w.t_near = QMIN; w.t_far = QMAX;
        add_row(f, 1, w);
        // zero direction, origin outside on y
        f = '{0, 5, 0, 0, 0, 0, -1, -1, -1, 1, 1, 1};
        w.hit = 0; w.t_near = QMAX; w.t_far = QMIN;
        add_row(f, 1, w);
        // reversed corners with zero direction
        f = '{0, 0, 0, 0, 0, 0, 1, -1, -1, -1, 1, 1};
        w.hit = 0; w.t_near = QMAX; w.t_far = QMIN;
        add_row(f, 1, w);
        // box behind the ray
        f = '{5 << FB, 0, 0, 1 << FB, 0, 0, -(1 << FB), -(1 << FB), -(1 << FB),
              1 << FB, 1 << FB, 1 << FB};
        add_row(f, 0, w);
        // extreme coordinates, some with tiny directions so that the quotients overflow
        f = '{QMIN, QMAX, QMIN, 1, -1, 1, QMAX, QMIN, QMIN, QMAX, QMAX, QMAX};
        add_row(f, 0, w);
        f = '{QMAX, QMIN, QMAX, -1, 1, QMIN, QMIN, QMIN, QMIN, QMAX, QMAX, QMAX};
        add_row(f, 0, w);
        f = '{QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN};
        add_row(f, 0, w);
        f = '{-1, -1, -1, QMIN, QMIN, QMIN, -1, -1, -1, -1, -1, -1};
        add_row(f, 0, w);
        // reversed corners with nonzero direction
        f = '{0, 0, 0, 1 << FB, 1 << FB, 1 << FB, 3 << FB, 3 << FB, 3 << FB,
              1 << FB, 1 << FB, 1 << FB};
        add_row(f, 0, w);
        // origin on a face, grazing
        f = '{1 << FB, 0, 0, 0, 1 << FB, 0, -(1 << FB), -(1 << FB), -(1 << FB),
              1 << FB, 1 << FB, 1 << FB};
        add_row(f, 0, w);
        f = '{0, 0, 0, -3, 7, -11, -100, -100, -100, 100, 100, 100};
        add_row(f, 0, w);

        foreach (rows[i])
        begin
            hits_pending.push_back(rows[i].known ? rows[i].want
                                                 : predict_hit(rows[i].ray_box));
            send_item(rows[i].ray_box);
        end
        s_axis_tvalid <= 1'b0;

        for (int n = 0; n < RANDOM_ITEMS; )
        begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < RANDOM_ITEMS; b++, n++)
            begin
                rb = random_ray();
                hits_pending.push_back(predict_hit(rb));
                send_item(rb);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (hits_pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        stall_idx <= (stall_idx + 1) % 64;
        if (stall_idx == 63)
            stall_pat <= ($urandom_range(0, 2) == 0) ? '1 : {$urandom, $urandom};
        if (rst_n)
            m_axis_tready <= stall_pat[stall_idx] | stall_pat[(stall_idx + 7) % 64];
    end

    initial stall_idx = 0;

    always @(posedge clk)
    begin
        hit_t got;
        hit_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[2*CW:0];
            if (hits_pending.size() == 0)
            begin
                $error("unexpected result item %h", got);
                error_count++;
            end
            else
            begin
                want = hits_pending.pop_front();
                if (got.hit !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, got.hit);
                    error_count++;
                end
                if (got.t_near !== want.t_near)
                begin
                    $error("t_near: expected %0d, got %0d", want.t_near, got.t_near);
                    error_count++;
                end
                if (got.t_far !== want.t_far)
                begin
                    $error("t_far: expected %0d, got %0d", want.t_far, got.t_far);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

endmodule
